// ===== rtl/load_power_denoise_daily_average_core_macros.svh =====
// Assertion macros used by the checker file of the load power denoise core.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef LOAD_POWER_DENOISE_DAILY_AVERAGE_CORE_MACROS_SVH
`define LOAD_POWER_DENOISE_DAILY_AVERAGE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LDDA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ldda check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define LDDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ldda check failed in the following cycle");

`endif

// ===== rtl/ldda_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants of the load power denoise and daily average core.
// Depends on nothing; every other file but the macros header imports it.
package ldda_pkg;

   localparam int LOAD_SLOTS  = 4;
   localparam int FIELD_W     = 16;
   localparam int AVG_W       = 24;
   localparam int FRAC_BITS   = 8;
   localparam int SPD_W       = 13;
   localparam int SPD_MAX     = (2 ** SPD_W) - 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [SPD_W-1:0] SPD_RESET = SPD_W'(1440);

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD_LOAD0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD_LOAD1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD_LOAD2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD_LOAD3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLES_PER_DAY = 3'd4;

   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [FIELD_W-1:0] power_load0;
      logic [FIELD_W-1:0] power_load1;
      logic [FIELD_W-1:0] power_load2;
      logic [FIELD_W-1:0] power_load3;
      logic               end_of_data;
   } req_payload_type;

   typedef struct packed {
      logic               result_kind;
      logic [FIELD_W-1:0] clean_load0;
      logic [FIELD_W-1:0] clean_load1;
      logic [FIELD_W-1:0] clean_load2;
      logic [FIELD_W-1:0] clean_load3;
      logic [LOAD_SLOTS-1:0] active_mask;
      logic [AVG_W-1:0]   average_load0;
      logic [AVG_W-1:0]   average_load1;
      logic [AVG_W-1:0]   average_load2;
      logic [AVG_W-1:0]   average_load3;
      logic [LOAD_SLOTS-1:0] enabled_mask;
      logic               last_of_run;
   } rsp_payload_type;

   // One classified sample as it waits between the front and the back.
   typedef struct packed {
      logic [LOAD_SLOTS-1:0][FIELD_W-1:0] clean;
      logic [LOAD_SLOTS-1:0]              active_mask;
      logic                               end_of_data;
   } queue_entry_type;

   // Fill status of the queue as the front and the back see it.
   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;

endpackage

// ===== rtl/ldda_channels.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample and result streams.
// Depends on ldda_pkg for the payload types.
interface ldda_req_if import ldda_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ldda_rsp_if import ldda_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/load_power_denoise_daily_average_core.sv =====
`timescale 1ns / 1ps
// Load power denoise and daily average: sample beats in, per-sample and day results out.
// Usage:
//   req_channel carries one beat per time step: four load powers in watts and
//   end_of_data. Each load is gated against its threshold register and summed.
//   rsp_channel returns a per-sample result for every beat; when the day is
//   complete (samples_per_day beats, or end_of_data) a day summary follows it
//   with each load's average in watts with 8 fraction bits.
//   csr_write_enable, csr_index and csr_write_data program thresholds 0..3 and
//   the day length (index 4); write only while the block is idle.
// Timing:
//   A per-sample beat passes through the two-entry queue and then the result
//   register, and one beat per cycle is sustained within a day while the
//   receiver takes results. After the day-closing beat the bit-serial divider
//   takes one quotient bit per cycle for all loads in parallel, then loads
//   the summary into the result register. The queue keeps taking beats
//   meanwhile, until it is full.
// Reset clears the day sums, the sample count and the channel state; the
// thresholds return to zero and the day length to 1440. When the receiver
// stalls, the result register holds its beat and the queue fills, after
// which req_channel.ready falls.
module load_power_denoise_daily_average_core import ldda_pkg::*; #(
   parameter int NUM_LOADS           = 4,
   parameter int MAX_SAMPLES_PER_DAY = 4096,
   parameter int SAMPLE_BITS         = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   ldda_req_if.sink               req_channel,
   ldda_rsp_if.source             rsp_channel
);

   logic [LOAD_SLOTS-1:0][FIELD_W-1:0] threshold_ff;
   logic [LOAD_SLOTS-1:0][FIELD_W-1:0] threshold_in;
   logic [SPD_W-1:0]                   spd_ff;
   logic [SPD_W-1:0]                   spd_in;

   queue_status_type queue_status;
   queue_entry_type  push_entry;
   queue_entry_type  pop_entry;
   logic             push_valid;
   logic             queue_pop;

   always_comb begin
      threshold_in = threshold_ff;
      spd_in       = spd_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_THRESHOLD_LOAD0: threshold_in[0] = csr_write_data;
            CSR_THRESHOLD_LOAD1: threshold_in[1] = csr_write_data;
            CSR_THRESHOLD_LOAD2: threshold_in[2] = csr_write_data;
            CSR_THRESHOLD_LOAD3: threshold_in[3] = csr_write_data;
            CSR_SAMPLES_PER_DAY: spd_in = csr_write_data[SPD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         spd_ff       <= SPD_RESET;
      end else begin
         threshold_ff <= threshold_in;
         spd_ff       <= spd_in;
      end
   end

   ldda_front #(
      .NUM_LOADS   (NUM_LOADS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .req_channel  (req_channel),
      .thresholds   (threshold_ff),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_entry   (push_entry)
   );

   ldda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (queue_pop),
      .pop_entry  (pop_entry),
      .status     (queue_status)
   );

   ldda_back #(
      .NUM_LOADS           (NUM_LOADS),
      .MAX_SAMPLES_PER_DAY (MAX_SAMPLES_PER_DAY),
      .SAMPLE_BITS         (SAMPLE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_status    (queue_status),
      .queue_entry     (pop_entry),
      .queue_pop       (queue_pop),
      .samples_per_day (spd_ff),
      .rsp_channel     (rsp_channel)
   );

endmodule

// ===== rtl/ldda_front.sv =====
`timescale 1ns / 1ps
// Front end: takes sample beats, gates each load against its threshold.
// Depends on ldda_pkg and ldda_req_if; feeds ldda_queue.
module ldda_front import ldda_pkg::*; #(
   parameter int NUM_LOADS   = 4,
   parameter int SAMPLE_BITS = 16
) (
   ldda_req_if.sink                          req_channel,
   input  logic [LOAD_SLOTS-1:0][FIELD_W-1:0] thresholds,
   input  queue_status_type                   queue_status,
   output logic                               push_valid,
   output queue_entry_type                    push_entry
);

   localparam int SAMPLE_W = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
   localparam logic [FIELD_W-1:0] SAMPLE_MASK = FIELD_W'((33'd1 << SAMPLE_W) - 33'd1);

   logic [LOAD_SLOTS-1:0][FIELD_W-1:0] power;

   assign power[0] = req_channel.payload.power_load0;
   assign power[1] = req_channel.payload.power_load1;
   assign power[2] = req_channel.payload.power_load2;
   assign power[3] = req_channel.payload.power_load3;

   assign req_channel.ready = queue_status.not_full;
   assign push_valid        = req_channel.valid && queue_status.not_full;

   always_comb begin
      logic [FIELD_W-1:0] sample;
      push_entry             = '0;
      push_entry.end_of_data = req_channel.payload.end_of_data;
      for (int k = 0; k < LOAD_SLOTS; k++) begin
         sample = power[k] & SAMPLE_MASK;
         // Only a sample strictly above the threshold passes.
         if ((k < NUM_LOADS) && (sample > thresholds[k])) begin
            push_entry.clean[k]       = sample;
            push_entry.active_mask[k] = 1'b1;
         end
      end
   end

endmodule

// ===== rtl/ldda_queue.sv =====
`timescale 1ns / 1ps
// Two-entry register queue between the front and the back.
// Depends on ldda_pkg for the entry and status types.
module ldda_queue import ldda_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  queue_entry_type  push_entry,
   input  logic             pop,
   output queue_entry_type  pop_entry,
   output queue_status_type status
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   queue_entry_type    entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;

   assign status.not_empty = (fill_ff != '0);
   assign status.not_full  = (fill_ff != FILL_W'(DEPTH));
   assign pop_entry        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_valid && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push_valid) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/ldda_back.sv =====
`timescale 1ns / 1ps
// Back end: accumulates day sums, divides at day end, drives the result register.
// Depends on ldda_pkg and ldda_rsp_if; is fed by ldda_queue.
module ldda_back import ldda_pkg::*; #(
   parameter int NUM_LOADS           = 4,
   parameter int MAX_SAMPLES_PER_DAY = 4096,
   parameter int SAMPLE_BITS         = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type queue_status,
   input  queue_entry_type  queue_entry,
   output logic             queue_pop,
   input  logic [SPD_W-1:0] samples_per_day,
   ldda_rsp_if.source       rsp_channel
);

   localparam int SAMPLE_W = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
   localparam int DAY_MAX  = (MAX_SAMPLES_PER_DAY < SPD_MAX) ? MAX_SAMPLES_PER_DAY : SPD_MAX;
   localparam int CNT_W    = $clog2(DAY_MAX + 1);
   localparam int SUM_W    = SAMPLE_W + CNT_W;
   localparam int Q_W      = SAMPLE_W + FRAC_BITS;
   localparam int STEP_W   = $clog2(Q_W);

   typedef enum logic [2:0] {
      BACK_RUN     = 3'b001,
      BACK_DIVIDE  = 3'b010,
      BACK_SUMMARY = 3'b100
   } back_state_type;

   back_state_type        state_ff;
   back_state_type        state_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [STEP_W-1:0]     step_ff;
   logic [STEP_W-1:0]     step_in;
   logic [SUM_W-1:0]      sum_ff [LOAD_SLOTS];
   logic [SUM_W-1:0]      sum_in [LOAD_SLOTS];
   logic [CNT_W-1:0]      rem_ff [LOAD_SLOTS];
   logic [CNT_W-1:0]      rem_in [LOAD_SLOTS];
   logic [Q_W-1:0]        work_ff [LOAD_SLOTS];
   logic [Q_W-1:0]        work_in [LOAD_SLOTS];
   logic [LOAD_SLOTS-1:0] enabled_ff;
   logic [LOAD_SLOTS-1:0] enabled_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   rsp_payload_type       out_payload_ff;
   rsp_payload_type       out_payload_in;

   logic [SUM_W-1:0]      sum_new [LOAD_SLOTS];
   logic [CNT_W-1:0]      rem_step [LOAD_SLOTS];
   logic [Q_W-1:0]        work_step [LOAD_SLOTS];
   logic [CNT_W-1:0]      day_len;
   logic [CNT_W-1:0]      count_new;
   logic                  close_day;
   logic                  out_free;

   assign rsp_channel.valid   = out_valid_ff;
   assign rsp_channel.payload = out_payload_ff;
   assign out_free            = !out_valid_ff || rsp_channel.ready;

   // Day length as programmed, held between one and the largest supported count.
   always_comb begin
      if (samples_per_day == '0) begin
         day_len = CNT_W'(1);
      end else if (32'(samples_per_day) > DAY_MAX) begin
         day_len = CNT_W'(DAY_MAX);
      end else begin
         day_len = CNT_W'(samples_per_day);
      end
   end

   assign count_new = count_ff + CNT_W'(1);
   assign close_day = queue_entry.end_of_data || (count_new >= day_len);

   // Sum update and one restoring division step per load lane.
   always_comb begin
      logic [CNT_W:0] partial;
      logic           fits;
      for (int k = 0; k < LOAD_SLOTS; k++) begin
         sum_new[k]   = sum_ff[k] + SUM_W'(queue_entry.clean[k][SAMPLE_W-1:0]);
         partial      = {rem_ff[k], work_ff[k][Q_W-1]};
         fits         = (partial >= {1'b0, count_ff});
         rem_step[k]  = fits ? CNT_W'(partial - {1'b0, count_ff}) : partial[CNT_W-1:0];
         work_step[k] = {work_ff[k][Q_W-2:0], fits};
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      sum_in         = sum_ff;
      rem_in         = rem_ff;
      work_in        = work_ff;
      enabled_in     = enabled_ff;
      out_valid_in   = out_valid_ff && !rsp_channel.ready;
      out_payload_in = out_payload_ff;
      queue_pop      = 1'b0;
      unique case (state_ff)
         BACK_RUN: begin
            if (queue_status.not_empty && out_free) begin
               queue_pop                  = 1'b1;
               sum_in                     = sum_new;
               count_in                   = count_new;
               out_valid_in               = 1'b1;
               out_payload_in             = '0;
               out_payload_in.result_kind = KIND_SAMPLE;
               out_payload_in.clean_load0 = queue_entry.clean[0];
               out_payload_in.clean_load1 = queue_entry.clean[1];
               out_payload_in.clean_load2 = queue_entry.clean[2];
               out_payload_in.clean_load3 = queue_entry.clean[3];
               out_payload_in.active_mask = queue_entry.active_mask;
               out_payload_in.last_of_run = !close_day;
               if (close_day) begin
                  state_in = BACK_DIVIDE;
                  step_in  = STEP_W'(Q_W - 1);
                  for (int k = 0; k < LOAD_SLOTS; k++) begin
                     // The quotient fits Q_W bits, so the upper sum bits start
                     // as a remainder already below the divisor.
                     rem_in[k]     = sum_new[k][SUM_W-1:SAMPLE_W];
                     work_in[k]    = {sum_new[k][SAMPLE_W-1:0], FRAC_BITS'(0)};
                     enabled_in[k] = (k < NUM_LOADS) && (sum_new[k] != '0);
                     sum_in[k]     = '0;
                  end
               end
            end
         end
         BACK_DIVIDE: begin
            rem_in  = rem_step;
            work_in = work_step;
            if (step_ff == '0) begin
               state_in = BACK_SUMMARY;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         BACK_SUMMARY: begin
            if (out_free) begin
               out_valid_in                 = 1'b1;
               out_payload_in               = '0;
               out_payload_in.result_kind   = KIND_SUMMARY;
               out_payload_in.average_load0 = AVG_W'(work_ff[0]);
               out_payload_in.average_load1 = AVG_W'(work_ff[1]);
               out_payload_in.average_load2 = AVG_W'(work_ff[2]);
               out_payload_in.average_load3 = AVG_W'(work_ff[3]);
               out_payload_in.enabled_mask  = enabled_ff;
               out_payload_in.last_of_run   = 1'b1;
               count_in                     = '0;
               state_in                     = BACK_RUN;
            end
         end
         default: begin
            state_in = BACK_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_RUN;
         count_ff     <= '0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < LOAD_SLOTS; k++) begin
            sum_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff         <= rem_in;
      work_ff        <= work_in;
      enabled_ff     <= enabled_in;
      out_payload_ff <= out_payload_in;
   end

endmodule

// ===== rtl/ldda_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the load power denoise core, bound to the top level.
// Depends on ldda_pkg and the assertion macros header.
`include "load_power_denoise_daily_average_core_macros.svh"

module ldda_checker import ldda_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   logic summary_due_ff;
   logic summary_due_in;
   logic rsp_beat;

   assign rsp_beat = rsp_valid && rsp_ready;

   // A per-sample beat without last_of_run must be followed by its day summary.
   always_comb begin
      summary_due_in = summary_due_ff;
      if (rsp_beat) begin
         summary_due_in = (rsp_payload.result_kind == KIND_SAMPLE) && !rsp_payload.last_of_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         summary_due_ff <= 1'b0;
      end else begin
         summary_due_ff <= summary_due_in;
      end
   end

   `LDDA_ASSERT_NOW(summary_when_due, clock, reset, rsp_valid && summary_due_ff, rsp_payload.result_kind == KIND_SUMMARY)
   `LDDA_ASSERT_NOW(sample_when_not_due, clock, reset, rsp_valid && !summary_due_ff, rsp_payload.result_kind == KIND_SAMPLE)
   `LDDA_ASSERT_NOW(summary_is_last, clock, reset, rsp_valid && (rsp_payload.result_kind == KIND_SUMMARY), rsp_payload.last_of_run && (rsp_payload.active_mask == '0))
   `LDDA_ASSERT_NOW(sample_has_no_average, clock, reset, rsp_valid && (rsp_payload.result_kind == KIND_SAMPLE), (rsp_payload.enabled_mask == '0) && (rsp_payload.average_load0 == '0))
   `LDDA_ASSERT_NEXT(stalled_beat_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind load_power_denoise_daily_average_core ldda_checker u_ldda_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_channel.valid),
   .rsp_ready   (rsp_channel.ready),
   .rsp_payload (rsp_channel.payload)
);
